// ===== src/scaled_alpha_keyed_blit_unit_defines.svh =====
// assertion macros for the scaled blit unit
// no dependencies; included by modules that carry assertions
`ifndef SCALED_ALPHA_KEYED_BLIT_UNIT_DEFINES_SVH
`define SCALED_ALPHA_KEYED_BLIT_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SAKB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SAKB_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define SAKB_ASSERT(label, clk, rst_n, prop, msg)
`define SAKB_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== src/sakb_pkg.sv =====
// shared types and constants for the scaled blit unit
// no dependencies
package sakb_pkg;
    localparam int unsigned COORD_W = 10;
    localparam int unsigned SRC_W_BITS = 8;
    localparam int unsigned IDX_W = 14;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RECT_X = 3'd0, CFG_RECT_Y = 3'd1, CFG_RECT_W = 3'd2,
        CFG_RECT_H = 3'd3, CFG_SRC_W = 3'd4, CFG_SRC_H = 3'd5
    } t_cfg_idx;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_DRAW = 1'b1;

    typedef struct packed {
        logic                  kind;
        logic [IDX_W-1:0]      texel_index;
        logic [7:0]            tex_blue;
        logic [7:0]            tex_green;
        logic [7:0]            tex_red;
        logic [7:0]            tex_alpha;
        logic [COORD_W-1:0]    dest_x;
        logic [COORD_W-1:0]    dest_y;
    } t_in_item;

    typedef struct packed {
        logic                  write_enable;
        logic [COORD_W-1:0]    out_x;
        logic [COORD_W-1:0]    out_y;
        logic [7:0]            out_blue;
        logic [7:0]            out_green;
        logic [7:0]            out_red;
    } t_out_item;

    typedef struct packed {
        logic [COORD_W-1:0]    rect_x;
        logic [COORD_W-1:0]    rect_y;
        logic [COORD_W-1:0]    rect_w;
        logic [COORD_W-1:0]    rect_h;
        logic [SRC_W_BITS-1:0] src_w;
        logic [SRC_W_BITS-1:0] src_h;
    } t_cfg;
endpackage

// ===== src/sakb_stream_if.sv =====
// valid/ready stream interface carrying one payload type
// no dependencies; the payload type is given by the parameter T
interface sakb_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/scaled_alpha_keyed_blit_unit.sv =====
// scaled_alpha_keyed_blit_unit: nearest-neighbour scaled blit with alpha key
// Channels: in_ch carries load and draw transactions, out_ch carries one
// result per draw transaction; loads give none. The user writes the six
// rectangle and source-size registers by index on the config port, only
// while the block is idle; the block does not enforce it. Throughput: one
// transaction per cycle unless out_ch stalls. A draw passes 23 register
// stages: an offset/bounds stage, a 10x8 multiply stage, an 18-stage
// pipelined divider (one quotient bit a stage), an address multiply-add
// stage (18x8 multiply plus add, the longest path), the memory read stage
// and the output stage. Loads travel down the same pipeline and write the
// texel memory at the memory read stage, the same place where draws read
// it, so loads and draws see the memory in the order they were accepted.
// Reset clears all valid bits and the config registers and holds in_ch
// ready low; the texel memory keeps no reset, reading an unloaded texel is
// undefined. A stall on out_ch freezes the whole pipeline together, so
// nothing is lost or repeated; in_ch ready is low only in reset or while
// the output register is full and not taken.
`include "scaled_alpha_keyed_blit_unit_defines.svh"
module scaled_alpha_keyed_blit_unit #(
    parameter int unsigned SCREEN_W = 1024,
    parameter int unsigned SCREEN_H = 1024,
    parameter int unsigned TEX_DIM = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    sakb_stream_if.sink                   in_ch,
    sakb_stream_if.source                 out_ch,
    input  logic                          i_cfg_we,
    input  logic [sakb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sakb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sakb_pkg::*;
    localparam int unsigned DEPTH = TEX_DIM * TEX_DIM;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned NUM_W = COORD_W + SRC_W_BITS;
    localparam int unsigned SIDE_W = 2 + 2 * COORD_W;
    localparam int unsigned LD_W = 1 + ADDR_W + 32;
    localparam int unsigned FADDR_W = 2 * SRC_W_BITS + NUM_W + 1;

    t_cfg r_cfg;
    t_in_item in_d;
    logic en;
    assign in_d = in_ch.data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{rect_x: '0, rect_y: '0, rect_w: '0, rect_h: '0,
                       src_w: SRC_W_BITS'(1), src_h: SRC_W_BITS'(1)};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RECT_X: r_cfg.rect_x <= i_cfg_data;
                CFG_RECT_Y: r_cfg.rect_y <= i_cfg_data;
                CFG_RECT_W: r_cfg.rect_w <= i_cfg_data;
                CFG_RECT_H: r_cfg.rect_h <= i_cfg_data;
                CFG_SRC_W:  r_cfg.src_w  <= i_cfg_data[SRC_W_BITS-1:0];
                CFG_SRC_H:  r_cfg.src_h  <= i_cfg_data[SRC_W_BITS-1:0];
                default: ;
            endcase
        end
    end

    // global enable: advance unless the output register holds untaken data
    logic r_out_vld;
    t_out_item r_out;
    assign en = !r_out_vld || out_ch.ready;
    assign in_ch.ready = en && i_rst_n;
    logic acc;
    assign acc = in_ch.valid && in_ch.ready;

    // texel load qualifier, address within the store
    logic load_ok;
    assign load_ok = (in_d.kind == KIND_LOAD) && (32'(in_d.texel_index) < DEPTH);

    // stage 1: offsets and bounds
    logic r1_vld, r1_in, r1_draw, r1_lwe;
    logic [ADDR_W-1:0] r1_laddr;
    logic [31:0] r1_ldata;
    logic [COORD_W-1:0] r1_ox, r1_oy, r1_x, r1_y;
    logic [COORD_W:0] n_endx, n_endy;
    assign n_endx = {1'b0, r_cfg.rect_x} + {1'b0, r_cfg.rect_w};
    assign n_endy = {1'b0, r_cfg.rect_y} + {1'b0, r_cfg.rect_h};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= acc;
        end
        if (en) begin
            r1_in <= (r_cfg.rect_w != '0) && (r_cfg.rect_h != '0)
                && (in_d.dest_x >= r_cfg.rect_x) && ({1'b0, in_d.dest_x} < n_endx)
                && (in_d.dest_y >= r_cfg.rect_y) && ({1'b0, in_d.dest_y} < n_endy)
                && (32'(in_d.dest_x) < 32'(SCREEN_W)) && (32'(in_d.dest_y) < 32'(SCREEN_H));
            r1_ox    <= in_d.dest_x - r_cfg.rect_x;
            r1_oy    <= in_d.dest_y - r_cfg.rect_y;
            r1_x     <= in_d.dest_x;
            r1_y     <= in_d.dest_y;
            r1_draw  <= (in_d.kind == KIND_DRAW);
            r1_lwe   <= load_ok;
            r1_laddr <= ADDR_W'(in_d.texel_index);
            r1_ldata <= {in_d.tex_alpha, in_d.tex_red, in_d.tex_green, in_d.tex_blue};
        end
    end

    // stage 2: scale by source size
    logic r2_vld, r2_in, r2_draw, r2_lwe;
    logic [ADDR_W-1:0] r2_laddr;
    logic [31:0] r2_ldata;
    logic [NUM_W-1:0] r2_nx, r2_ny;
    logic [COORD_W-1:0] r2_x, r2_y;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
        if (en) begin
            r2_in    <= r1_in;
            r2_nx    <= NUM_W'(r1_ox) * NUM_W'(r_cfg.src_w);
            r2_ny    <= NUM_W'(r1_oy) * NUM_W'(r_cfg.src_h);
            r2_x     <= r1_x;
            r2_y     <= r1_y;
            r2_draw  <= r1_draw;
            r2_lwe   <= r1_lwe;
            r2_laddr <= r1_laddr;
            r2_ldata <= r1_ldata;
        end
    end

    // pipelined dividers for column and row, load data rides with the row
    logic dx_vld, dy_vld;
    logic [NUM_W-1:0] q_col, q_row;
    logic [SIDE_W-1:0] side_x;
    logic [LD_W-1:0] side_y;
    sakb_divider #(.NUM_W(NUM_W), .DEN_W(COORD_W), .SIDE_W(SIDE_W)) u_div_col (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r2_vld), .i_num(r2_nx),
        .i_den(r_cfg.rect_w), .i_side({r2_draw, r2_in, r2_x, r2_y}),
        .o_valid(dx_vld), .o_quot(q_col), .o_side(side_x));
    sakb_divider #(.NUM_W(NUM_W), .DEN_W(COORD_W), .SIDE_W(LD_W)) u_div_row (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r2_vld), .i_num(r2_ny),
        .i_den(r_cfg.rect_h), .i_side({r2_lwe, r2_laddr, r2_ldata}),
        .o_valid(dy_vld), .o_quot(q_row), .o_side(side_y));

    // stage 3: texel address, and texel load in program order
    logic r3_vld, r3_ok, r3_draw, r3_lwe;
    logic [ADDR_W-1:0] r3_addr, r3_laddr;
    logic [31:0] r3_ldata;
    logic [COORD_W-1:0] r3_x, r3_y;
    logic [FADDR_W-1:0] n_faddr;
    assign n_faddr = FADDR_W'(q_row) * FADDR_W'(r_cfg.src_w) + FADDR_W'(q_col);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= dx_vld;
        end
        if (en) begin
            r3_draw  <= side_x[SIDE_W-1];
            r3_ok    <= side_x[SIDE_W-2] && (n_faddr < FADDR_W'(DEPTH));
            r3_addr  <= n_faddr[ADDR_W-1:0];
            r3_x     <= side_x[2*COORD_W-1:COORD_W];
            r3_y     <= side_x[COORD_W-1:0];
            r3_lwe   <= side_y[LD_W-1];
            r3_laddr <= side_y[LD_W-2:32];
            r3_ldata <= side_y[31:0];
        end
    end

    // stage 4: memory read
    logic [31:0] rdata;
    logic store_we;
    logic r4_vld, r4_ok, r4_draw;
    logic [COORD_W-1:0] r4_x, r4_y;
    assign store_we = en && r3_vld && r3_lwe;
    sakb_texel_store #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_store (
        .i_clk, .i_en(en), .i_we(store_we), .i_waddr(r3_laddr),
        .i_wdata(r3_ldata), .i_raddr(r3_addr), .o_rdata(rdata));
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (en) begin
            r4_vld <= r3_vld;
        end
        if (en) begin
            r4_ok   <= r3_ok;
            r4_draw <= r3_draw;
            r4_x    <= r3_x;
            r4_y    <= r3_y;
        end
    end

    // output register with alpha key, draws only
    logic hit;
    assign hit = r4_ok && (rdata[31:24] != 8'd0);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r4_vld && r4_draw;
        end
        if (en) begin
            r_out.write_enable <= hit;
            r_out.out_x        <= r4_x;
            r_out.out_y        <= r4_y;
            r_out.out_blue     <= hit ? rdata[7:0] : 8'd0;
            r_out.out_green    <= hit ? rdata[15:8] : 8'd0;
            r_out.out_red      <= hit ? rdata[23:16] : 8'd0;
        end
    end
    assign out_ch.valid = r_out_vld;
    assign out_ch.data  = r_out;

    // checks
    `SAKB_ASSERT(a_div_lockstep, i_clk, i_rst_n, dx_vld == dy_vld, "dividers out of step")
    `SAKB_ASSERT_NEXT(a_hold_stall, i_clk, i_rst_n, r_out_vld && !out_ch.ready, r_out_vld && $stable(r_out), "result changed under stall")
    `SAKB_ASSERT_NEXT(a_load_no_out, i_clk, i_rst_n, en && r4_vld && !r4_draw, !r_out_vld, "load gave a result")
    `SAKB_ASSERT_NEXT(a_miss_black, i_clk, i_rst_n, en && r4_vld && !r4_ok, !r_out.write_enable && r_out.out_red == 8'd0, "miss must not write")
endmodule

// ===== src/sakb_divider.sv =====
// pipelined restoring divider, one quotient bit per stage
// depends on sakb_pkg; side payload travels with the quotient
module sakb_divider #(
    parameter int unsigned NUM_W = 18,
    parameter int unsigned DEN_W = 10,
    parameter int unsigned SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [NUM_W-1:0]  o_quot,
    output logic [SIDE_W-1:0] o_side
);
    import sakb_pkg::*;
    localparam int unsigned REM_W = DEN_W + 1;

    logic              r_vld  [NUM_W+1];
    logic [NUM_W-1:0]  r_num  [NUM_W+1];
    logic [REM_W-1:0]  r_rem  [NUM_W+1];
    logic [DEN_W-1:0]  r_den  [NUM_W+1];
    logic [SIDE_W-1:0] r_side [NUM_W+1];

    always_comb begin
        r_vld[0]  = i_valid;
        r_num[0]  = i_num;
        r_rem[0]  = '0;
        r_den[0]  = i_den;
        r_side[0] = i_side;
    end

    // one subtract and compare per stage
    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic [REM_W-1:0] n_trial;
        logic [REM_W-1:0] n_rem;
        logic [NUM_W-1:0] n_num;
        always_comb begin
            n_trial = {r_rem[s][DEN_W-1:0], r_num[s][NUM_W-1]};
            n_num   = {r_num[s][NUM_W-2:0], 1'b0};
            n_rem   = n_trial;
            if (n_trial >= {1'b0, r_den[s]}) begin
                n_rem    = n_trial - {1'b0, r_den[s]};
                n_num[0] = 1'b1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= r_vld[s];
            end
            if (i_en) begin
                r_num[s+1]  <= n_num;
                r_rem[s+1]  <= n_rem;
                r_den[s+1]  <= r_den[s];
                r_side[s+1] <= r_side[s];
            end
        end
    end

    assign o_valid = r_vld[NUM_W];
    assign o_quot  = r_num[NUM_W];
    assign o_side  = r_side[NUM_W];
endmodule

// ===== src/sakb_texel_store.sv =====
// texel memory with registered read, loads and lookups share the pipeline
// depends on sakb_pkg
module sakb_texel_store #(
    parameter int unsigned DEPTH = 16384,
    parameter int unsigned ADDR_W = 14
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [31:0]       i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [31:0]       o_rdata
);
    import sakb_pkg::*;
    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    // single write port, single registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end
    assign o_rdata = r_rdata;
endmodule
